// ----- hw/rtl/csv_pkg.sv -----
`timescale 1ns / 1ps

package csv_pkg;

	// Datapath widths
	localparam int PROD_W   = 65;  // signed product of a 49-bit operand and a 16-bit gain
	localparam int MAG_W    = 64;  // magnitude handled by the divider
	localparam int DEN_W    = 15;  // divisor width
	localparam int OPA_W    = 49;  // widest multiplier operand (corrected velocity error)
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CIDX_W   = 3;
	localparam int STEP_W   = 6;
	localparam int DIV_STEPS = 64;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_POS_GAIN = 3'd0;
	localparam logic [CIDX_W-1:0] REG_INT_GAIN = 3'd1;
	localparam logic [CIDX_W-1:0] REG_VEL_GAIN = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GAIN_DIV = 3'd3;
	localparam logic [CIDX_W-1:0] REG_VEL_LIM  = 3'd4;

	// Drive bounds
	localparam logic signed [7:0] DRIVE_MAX = 8'sd127;
	localparam logic signed [7:0] DRIVE_MIN = -8'sd127;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_POS,
		ST_DIV_POS_GO,
		ST_DIV_POS_WAIT,
		ST_LIMIT,
		ST_MUL_INT,
		ST_DIV_INT_GO,
		ST_DIV_INT_WAIT,
		ST_MUL_DRV,
		ST_DIV_DRV_GO,
		ST_DIV_DRV_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MUL_POS,
		MUL_INT,
		MUL_DRV
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     sp_from_div;
		logic     sp_limit;
		logic     verr_en;
		logic     d_from_div;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

// ----- hw/rtl/csv_div.sv -----
`timescale 1ns / 1ps

module csv_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [csv_pkg::PROD_W-1:0]    dividend,
	input  logic        [csv_pkg::DEN_W-1:0]     divisor,
	output logic                                 done,
	output logic signed [csv_pkg::PROD_W-1:0]    quotient
);

	logic                           busy_q;
	logic                           fix_q;
	logic                           done_q;
	logic [csv_pkg::STEP_W-1:0]     cnt_q;
	logic [csv_pkg::MAG_W-1:0]      num_q;
	logic [csv_pkg::DEN_W-1:0]      rem_q;
	logic [csv_pkg::DEN_W-1:0]      den_q;
	logic                           neg_q;
	logic signed [csv_pkg::PROD_W-1:0] quot_q;

	logic [csv_pkg::PROD_W-1:0]     dvd_neg;
	logic [csv_pkg::MAG_W-1:0]      dvd_mag;
	logic [csv_pkg::DEN_W:0]        trial;
	logic [csv_pkg::DEN_W:0]        trial_sub;
	logic                           q_bit;
	logic [csv_pkg::PROD_W-1:0]     q_ext;

	// Take the magnitude of the dividend; the divisor is always positive
	always_comb begin
		dvd_neg = -dividend;
		dvd_mag = dividend[csv_pkg::PROD_W-1] ? dvd_neg[csv_pkg::MAG_W-1:0]
			: dividend[csv_pkg::MAG_W-1:0];
		trial     = {rem_q, num_q[csv_pkg::MAG_W-1]};
		trial_sub = trial - {1'b0, den_q};
		q_bit     = (trial >= {1'b0, den_q});
		q_ext     = {1'b0, num_q};
	end

	// Control: one quotient bit a cycle, then a sign fix cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= csv_pkg::STEP_W'(csv_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Restoring division datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dvd_mag;
			rem_q <= '0;
			neg_q <= dividend[csv_pkg::PROD_W-1];
			den_q <= (divisor == '0) ? csv_pkg::DEN_W'(1) : divisor;
		end else if (busy_q) begin
			num_q <= {num_q[csv_pkg::MAG_W-2:0], q_bit};
			rem_q <= q_bit ? trial_sub[csv_pkg::DEN_W-1:0] : trial[csv_pkg::DEN_W-1:0];
		end else if (fix_q) begin
			quot_q <= neg_q ? -$signed(q_ext) : $signed(q_ext);
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- hw/rtl/csv_dp.sv -----
`timescale 1ns / 1ps

module csv_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  csv_pkg::cmd_t                     cmd,
	output csv_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [csv_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [csv_pkg::CFG_W-1:0]         cfg_data,
	input  logic signed [31:0]                measured_position,
	input  logic signed [15:0]                measured_velocity,
	input  logic signed [31:0]                position_target,
	input  logic signed [15:0]                velocity_target,
	output logic signed [7:0]                 drive_value,
	output logic signed [15:0]                velocity_setpoint,
	output logic                              drive_saturated
);

	// Configuration and state
	logic signed [15:0]                   kp_q;
	logic signed [15:0]                   ki_q;
	logic signed [15:0]                   kv_q;
	logic [csv_pkg::DEN_W-1:0]            gd_q;
	logic [14:0]                          lim_q;
	logic signed [31:0]                   integ_q;

	// Working registers
	logic signed [32:0]                   err_q;
	logic signed [15:0]                   mvel_q;
	logic signed [15:0]                   sp_q;
	logic signed [16:0]                   verr_q;
	logic signed [csv_pkg::OPA_W-1:0]     d_q;
	logic signed [csv_pkg::PROD_W-1:0]    prod_q;
	logic signed [7:0]                    drive_q;
	logic signed [15:0]                   osp_q;
	logic                                 sat_q;

	logic signed [csv_pkg::OPA_W-1:0]     mul_a;
	logic signed [csv_pkg::GAIN_W-1:0]    mul_b;
	logic signed [csv_pkg::PROD_W-1:0]    mul_p;
	logic                                 div_done;
	logic signed [csv_pkg::PROD_W-1:0]    dq;

	logic signed [15:0]                   sp_sat;
	logic signed [16:0]                   sp_ext;
	logic signed [16:0]                   lim_pos;
	logic signed [16:0]                   lim_neg;
	logic signed [15:0]                   sp_clamped;
	logic signed [7:0]                    drive_c;
	logic                                 sat_c;
	logic signed [32:0]                   int_sum;
	logic signed [31:0]                   int_next;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			ki_q  <= '0;
			kv_q  <= '0;
			gd_q  <= csv_pkg::DEN_W'(1);
			lim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csv_pkg::REG_POS_GAIN: kp_q  <= cfg_data;
				csv_pkg::REG_INT_GAIN: ki_q  <= cfg_data;
				csv_pkg::REG_VEL_GAIN: kv_q  <= cfg_data;
				csv_pkg::REG_GAIN_DIV: gd_q  <= cfg_data[csv_pkg::DEN_W-1:0];
				csv_pkg::REG_VEL_LIM:  lim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Select multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			csv_pkg::MUL_POS: begin
				mul_a = {{(csv_pkg::OPA_W-33){err_q[32]}}, err_q};
				mul_b = kp_q;
			end
			csv_pkg::MUL_INT: begin
				mul_a = {{(csv_pkg::OPA_W-32){integ_q[31]}}, integ_q};
				mul_b = ki_q;
			end
			csv_pkg::MUL_DRV: begin
				mul_a = d_q;
				mul_b = kv_q;
			end
			default: begin
				mul_a = d_q;
				mul_b = kv_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	csv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (gd_q),
		.done     (div_done),
		.quotient (dq)
	);

	assign sts.div_done = div_done;

	// Setpoint saturation, limit clamp, drive clamp and integral update
	always_comb begin
		if (dq > 65'sd32767)
			sp_sat = 16'sh7FFF;
		else if (dq < -65'sd32768)
			sp_sat = 16'sh8000;
		else
			sp_sat = dq[15:0];

		sp_ext  = {sp_q[15], sp_q};
		lim_pos = {2'b00, lim_q};
		lim_neg = -lim_pos;
		if (lim_q != '0 && sp_ext > lim_pos)
			sp_clamped = lim_pos[15:0];
		else if (lim_q != '0 && sp_ext < lim_neg)
			sp_clamped = lim_neg[15:0];
		else
			sp_clamped = sp_q;

		int_sum = {integ_q[31], integ_q} + {{16{verr_q[16]}}, verr_q};
		if (int_sum[32] != int_sum[31])
			int_next = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			int_next = int_sum[31:0];

		if (dq > 65'sd127) begin
			drive_c = csv_pkg::DRIVE_MAX;
			sat_c   = 1'b1;
		end else if (dq < -65'sd127) begin
			drive_c = csv_pkg::DRIVE_MIN;
			sat_c   = 1'b1;
		end else begin
			drive_c = dq[7:0];
			sat_c   = 1'b0;
		end
	end

	// Integral state: hold while the drive is clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_q <= '0;
		else if (cmd.finish && !sat_c)
			integ_q <= int_next;
	end

	// Working and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q  <= {position_target[31], position_target}
				- {measured_position[31], measured_position};
			mvel_q <= measured_velocity;
			sp_q   <= velocity_target;
		end
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.sp_from_div)
			sp_q <= sp_sat;
		if (cmd.sp_limit)
			sp_q <= sp_clamped;
		if (cmd.verr_en)
			verr_q <= {sp_q[15], sp_q} - {mvel_q[15], mvel_q};
		if (cmd.d_from_div)
			d_q <= {{(csv_pkg::OPA_W-17){verr_q[16]}}, verr_q} + dq[csv_pkg::OPA_W-1:0];
		if (cmd.finish) begin
			drive_q <= drive_c;
			osp_q   <= sp_q;
			sat_q   <= sat_c;
		end
	end

	assign drive_value       = drive_q;
	assign velocity_setpoint = osp_q;
	assign drive_saturated   = sat_q;

endmodule

// ----- hw/rtl/csv_ctrl.sv -----
`timescale 1ns / 1ps

module csv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            position_mode,
	output logic            out_valid,
	input  logic            out_stall,
	input  csv_pkg::sts_t   sts,
	output csv_pkg::cmd_t   cmd
);

	csv_pkg::state_t state_q;
	csv_pkg::state_t state_d;
	logic            out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= csv_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = csv_pkg::MUL_POS;
		unique case (state_q)
			csv_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = position_mode ? csv_pkg::ST_MUL_POS : csv_pkg::ST_LIMIT;
				end
			end
			csv_pkg::ST_MUL_POS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = csv_pkg::MUL_POS;
				state_d     = csv_pkg::ST_DIV_POS_GO;
			end
			csv_pkg::ST_DIV_POS_GO: begin
				cmd.div_start = 1'b1;
				state_d       = csv_pkg::ST_DIV_POS_WAIT;
			end
			csv_pkg::ST_DIV_POS_WAIT: begin
				if (sts.div_done) begin
					cmd.sp_from_div = 1'b1;
					state_d         = csv_pkg::ST_LIMIT;
				end
			end
			csv_pkg::ST_LIMIT: begin
				cmd.sp_limit = 1'b1;
				state_d      = csv_pkg::ST_MUL_INT;
			end
			csv_pkg::ST_MUL_INT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = csv_pkg::MUL_INT;
				cmd.verr_en = 1'b1;
				state_d     = csv_pkg::ST_DIV_INT_GO;
			end
			csv_pkg::ST_DIV_INT_GO: begin
				cmd.div_start = 1'b1;
				state_d       = csv_pkg::ST_DIV_INT_WAIT;
			end
			csv_pkg::ST_DIV_INT_WAIT: begin
				if (sts.div_done) begin
					cmd.d_from_div = 1'b1;
					state_d        = csv_pkg::ST_MUL_DRV;
				end
			end
			csv_pkg::ST_MUL_DRV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = csv_pkg::MUL_DRV;
				state_d     = csv_pkg::ST_DIV_DRV_GO;
			end
			csv_pkg::ST_DIV_DRV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = csv_pkg::ST_DIV_DRV_WAIT;
			end
			csv_pkg::ST_DIV_DRV_WAIT: begin
				if (sts.div_done)
					state_d = csv_pkg::ST_FINISH;
			end
			csv_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = csv_pkg::ST_IDLE;
				end
			end
			default: state_d = csv_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != csv_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/cascaded_pi_servo_controller_unit.sv -----
`timescale 1ns / 1ps

// Cascaded position/velocity PI servo with anti-windup. Each item is one control
// tick and yields one result: the clamped drive value, the velocity setpoint in
// use and a flag telling whether the drive was clamped (the integral then holds).
// Items are processed one at a time; in_stall stays high from acceptance until
// the result is written to the output register, which can still be waiting for
// the consumer while the next item is taken. The next item can be taken in the
// cycle after the result is written; the write waits while the output register
// still holds an unread result and out_stall is high. Most of the time goes to
// the shared 64-step restoring divider (each division with its start, sign fix
// and done steps; three divisions in position mode, two in velocity mode), the
// rest to the shared multiplier and clamps.
// Configuration registers (index 0..4: position gain, integral gain, velocity
// gain, gain divisor, velocity limit) may be written only while the block is idle.

module cascaded_pi_servo_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csv_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [csv_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            position_mode,
	input  logic signed [31:0]              measured_position,
	input  logic signed [15:0]              measured_velocity,
	input  logic signed [31:0]              position_target,
	input  logic signed [15:0]              velocity_target,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [7:0]               drive_value,
	output logic signed [15:0]              velocity_setpoint,
	output logic                            drive_saturated
);

	csv_pkg::cmd_t cmd;
	csv_pkg::sts_t sts;

	csv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.position_mode (position_mode),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	csv_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.measured_position (measured_position),
		.measured_velocity (measured_velocity),
		.position_target   (position_target),
		.velocity_target   (velocity_target),
		.drive_value       (drive_value),
		.velocity_setpoint (velocity_setpoint),
		.drive_saturated   (drive_saturated)
	);

	// An accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting an item");

	// A new result only appears after the block was working on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

	// A clamped drive sits exactly at one of the bounds
	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_saturated |-> drive_value == csv_pkg::DRIVE_MAX
			|| drive_value == csv_pkg::DRIVE_MIN)
		else $error("saturated drive not at a bound");

endmodule
